FILE: design/dgpw_pkg.sv
// ----------------------------------------------------------------------------
// dgpw_pkg
// Shared types, constants and the fixed-point 2^-x function of the
// directional gaussian point warp.
// ----------------------------------------------------------------------------
`default_nettype none

package dgpw_pkg;

  localparam int MAX_CONTROLS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  // p vector width: origin minus a reference point of up to 24 bits
  localparam int P_W      = 25;
  localparam int RAD_W    = 52;
  localparam int ROOT_W   = 26;
  localparam int NUM_W    = 52;
  localparam int DEN_W    = 26;

  localparam logic [15:0] SPREAD_RESET = 16'd8000;
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;

  // configuration register indexes
  localparam logic [1:0] CFG_WARP_MODE     = 2'd0;
  localparam logic [1:0] CFG_CONTROL_COUNT = 2'd1;
  localparam logic [1:0] CFG_SPREAD_SCALE  = 2'd2;

  // request kinds on tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_WARP = 1'b1;

  typedef struct packed {
    logic signed [P_W-1:0] px;
    logic signed [P_W-1:0] py;
    logic signed [15:0]    vx;
    logic signed [15:0]    vy;
  } wgt_req_t;

  // 2^(k/16) in Q16
  localparam logic [17:0] POW2_TAB [17] = '{
    18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
    18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120193, 18'd125515, 18'd131072
  };

  // 2^(-x/65536) in Q16, x below 2^21
  function automatic logic [16:0] exp2_neg(input logic [20:0] x);
    logic [4:0]  n;
    logic [16:0] t;
    logic [4:0]  idx;
    logic [11:0] f;
    logic [17:0] lo_v;
    logic [17:0] hi_v;
    logic [29:0] slope;
    logic [17:0] fr;
    logic [49:0] sh;
    n     = x[20:16];
    t     = 17'h10000 - {1'b0, x[15:0]};
    idx   = t[16:12];
    f     = t[11:0];
    lo_v  = '0;
    hi_v  = '0;
    slope = '0;
    if (idx >= 5'd16) begin
      fr = POW2_TAB[16];
    end else begin
      lo_v  = POW2_TAB[idx];
      hi_v  = POW2_TAB[idx + 5'd1];
      slope = 30'(hi_v - lo_v) * 30'(f);
      fr    = lo_v + 18'(slope >> 12);
    end
    sh = {32'b0, fr} >> (6'(n) + 6'd1);
    return sh[16:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/directional_gaussian_point_warp_top.sv
// Sequence: a load request is written to the table when it is taken; a point
// is presented after one pass per applied control. A control costs a read, a
// start and the weight sequence, set by three divisions and two square roots;
// a zero vector ends a control early.
// Throughput: one request at a time; the next is taken once the point is done.
// Reset: registers return to mode 0, count 0, spread 8000; table undefined.
// ----------------------------------------------------------------------------
// directional_gaussian_point_warp_top
// Control table in memory, one control applied per pass through the weight
// sequencer, point carried in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_gaussian_point_warp_top import dgpw_pkg::*; #(
  parameter int MAX_CONTROLS = MAX_CONTROLS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index[3:0], coord_x[19:4], coord_y[35:20], drag_x[51:36],
  // drag_y[67:52], zero fill [71:68]
  input  wire logic [71:0] s_axis_tdata,
  // func
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // moved_x[15:0], moved_y[31:16]
  output logic      [31:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW   = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
  localparam int NW   = $clog2(MAX_CONTROLS + 1);
  localparam int CW   = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int SW   = CW + 18;
  localparam int QW   = CW + 2;
  localparam int CMAX_I = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN_I = -(1 << (COORD_BITS - 1));
  localparam logic signed [QW-1:0] CMAX = QW'(CMAX_I);
  localparam logic signed [QW-1:0] CMIN = QW'(CMIN_I);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_RD    = 5'b00010,
    T_START = 5'b00100,
    T_WAIT  = 5'b01000,
    T_DONE  = 5'b10000
  } tstate_e;

  tstate_e state_q, state_d;

  logic        mode_q;
  logic [4:0]  count_q;
  logic [15:0] spread_q;

  logic signed [CW-1:0] x0_q [2];
  logic signed [CW-1:0] cx_q [2];
  logic signed [CW-1:0] cx_d [2];
  logic [NW-1:0]        n_q, idx_q, n_d;
  logic                 out_valid_q;
  logic [31:0]          out_data_q;

  logic        in_fire, load_fire, warp_fire, out_free, done_fire;
  logic        mem_we;
  logic [63:0] rdata;
  wgt_req_t    wreq;
  logic        wgt_start, wgt_done;
  logic [15:0] wgt;

  logic signed [15:0]    org [2];
  logic signed [15:0]    drg [2];
  logic signed [P_W-1:0] pv  [2];
  logic signed [P_W-1:0] ce  [2];
  logic [15:0]           sat16 [2];

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load_fire     = in_fire && (s_axis_tuser == FUNC_LOAD);
  assign warp_fire     = in_fire && (s_axis_tuser == FUNC_WARP);
  assign mem_we        = load_fire && (32'(s_axis_tdata[3:0]) < MAX_CONTROLS);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign done_fire     = (state_q == T_DONE) && out_free;
  assign wgt_start     = (state_q == T_START);
  assign n_d = (32'(count_q) > MAX_CONTROLS) ? NW'(MAX_CONTROLS) : NW'(count_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      count_q  <= '0;
      spread_q <= SPREAD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WARP_MODE:     mode_q   <= cfg_data_i[0];
        CFG_CONTROL_COUNT: count_q  <= cfg_data_i[4:0];
        CFG_SPREAD_SCALE:  spread_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dgpw_ctrl_mem #(.DEPTH(MAX_CONTROLS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(s_axis_tdata[3:0])),
    .wdata_i (s_axis_tdata[67:4]),
    .raddr_i (AW'(idx_q)),
    .rdata_o (rdata)
  );

  // per-coordinate datapath
  always_comb begin
    logic signed [CW-1:0] rp;
    logic signed [32:0]   mv;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] q;
    logic signed [QW-1:0] qn;
    org[0] = rdata[15:0];
    org[1] = rdata[31:16];
    drg[0] = rdata[47:32];
    drg[1] = rdata[63:48];
    for (int k = 0; k < 2; k++) begin
      rp    = mode_q ? cx_q[k] : x0_q[k];
      pv[k] = P_W'(org[k]) - P_W'(rp);
      mv    = $signed({1'b0, wgt}) * 33'(drg[k]);
      s     = (SW'(cx_q[k]) <<< 16) + SW'(mv);
      q     = s[SW-1] ? ((s + SW'(65535)) >>> 16) : (s >>> 16);
      qn    = q[QW-1:0];
      if (qn > CMAX)      cx_d[k] = CW'(CMAX);
      else if (qn < CMIN) cx_d[k] = CW'(CMIN);
      else                cx_d[k] = qn[CW-1:0];
      ce[k] = P_W'(cx_q[k]);
      if (ce[k] > 25'sd32767)       sat16[k] = 16'h7FFF;
      else if (ce[k] < -25'sd32768) sat16[k] = 16'h8000;
      else                          sat16[k] = ce[k][15:0];
    end
  end

  assign wreq.px = pv[0];
  assign wreq.py = pv[1];
  assign wreq.vx = drg[0];
  assign wreq.vy = drg[1];

  dgpw_weight u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wgt_start),
    .req_i    (wreq),
    .spread_i (spread_q),
    .done_o   (wgt_done),
    .weight_o (wgt)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (warp_fire) state_d = (n_d == '0) ? T_DONE : T_RD;
      T_RD:    state_d = T_START;
      T_START: state_d = T_WAIT;
      T_WAIT:  if (wgt_done) state_d = (idx_q + NW'(1) == n_q) ? T_DONE : T_RD;
      T_DONE:  if (out_free) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      if (done_fire)          out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (warp_fire) begin
        idx_q <= '0;
        n_q   <= n_d;
      end else if (state_q == T_WAIT && wgt_done) begin
        idx_q <= idx_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (warp_fire) begin
      x0_q[0] <= CW'($signed(s_axis_tdata[19:4]));
      x0_q[1] <= CW'($signed(s_axis_tdata[35:20]));
      cx_q[0] <= CW'($signed(s_axis_tdata[19:4]));
      cx_q[1] <= CW'($signed(s_axis_tdata[35:20]));
    end else if (state_q == T_WAIT && wgt_done) begin
      cx_q[0] <= cx_d[0];
      cx_q[1] <= cx_d[1];
    end
    if (done_fire) begin
      out_data_q <= {sat16[1], sat16[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_RD) |-> (idx_q < n_q))
    else $error("control index past the applied count");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wgt_done |-> (state_q == T_WAIT))
    else $error("weight finished outside a control pass");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire |=> m_axis_tvalid)
    else $error("finished point not presented");

endmodule

`default_nettype wire

FILE: design/dgpw_ctrl_mem.sv
// ----------------------------------------------------------------------------
// dgpw_ctrl_mem
// Control table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_ctrl_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [63:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [63:0]   rdata_o
);

  logic [63:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/dgpw_isqrt.sv
// ----------------------------------------------------------------------------
// dgpw_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_isqrt import dgpw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAD_W-1:0]  radicand_i,
  output logic                   done_o,
  output logic      [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0] x_q, r_q, bit_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [RAD_W:0]   trial;
  logic             ge;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};
  assign ge    = {1'b0, x_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= RAD_W'(1) << (2 * ROOT_W - 2);
    end else if (busy_q) begin
      if (ge) begin
        x_q <= x_q - trial[RAD_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: design/dgpw_div.sv
// ----------------------------------------------------------------------------
// dgpw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_div import dgpw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_q, quo_q[NUM_W-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: design/dgpw_weight.sv
// ----------------------------------------------------------------------------
// dgpw_weight
// Gaussian weight of one control: sequencer around one shared multiplier,
// the square root unit and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dgpw_weight import dgpw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire wgt_req_t    req_i,
  input  wire logic [15:0] spread_i,
  output logic             done_o,
  output logic      [15:0] weight_o
);

  typedef enum logic [17:0] {
    W_IDLE = 18'(1) << 0,
    W_M1   = 18'(1) << 1,
    W_M2   = 18'(1) << 2,
    W_M3   = 18'(1) << 3,
    W_M4   = 18'(1) << 4,
    W_M5   = 18'(1) << 5,
    W_M6   = 18'(1) << 6,
    W_CHK  = 18'(1) << 7,
    W_SQP  = 18'(1) << 8,
    W_SQV  = 18'(1) << 9,
    W_DT   = 18'(1) << 10,
    W_DC   = 18'(1) << 11,
    W_G    = 18'(1) << 12,
    W_PL   = 18'(1) << 13,
    W_PH   = 18'(1) << 14,
    W_DS   = 18'(1) << 15,
    W_DE   = 18'(1) << 16,
    W_X    = 18'(1) << 17
  } wstate_e;

  wstate_e state_q, state_d;

  wgt_req_t           req_q;
  logic [49:0]        d_q;
  logic [31:0]        vv_q;
  logic signed [41:0] dot_q;
  logic [ROOT_W-1:0]  np_q, nv_q;
  logic [16:0]        c_q, g_q;
  logic [NUM_W-1:0]   prod_q;
  logic [19:0]        e_q;
  logic [20:0]        x_q;
  logic [15:0]        weight_q;
  logic               done_q, fin_x;

  logic signed [P_W-1:0] mul_a, mul_b;
  logic signed [49:0]    mprod;
  logic [41:0]           mag;
  logic [17:0]           y;
  logic [20:0]           e2_in;
  logic [16:0]           e2_out;
  logic                  zero_vec;

  logic              sq_start, sq_done;
  logic [RAD_W-1:0]  sq_in;
  logic [ROOT_W-1:0] sq_root;
  logic              dv_start, dv_done;
  logic [NUM_W-1:0]  dv_num, dv_quo;
  logic [DEN_W-1:0]  dv_den;

  assign zero_vec = (req_i.vx == '0 && req_i.vy == '0) ||
                    (req_i.px == '0 && req_i.py == '0);
  assign mag      = dot_q[41] ? 42'(-dot_q) : 42'(dot_q);
  assign y        = dot_q[41] ? 18'd65536 + 18'(c_q) : 18'd65536 - 18'(c_q);
  assign mprod    = mul_a * mul_b;
  assign e2_in    = (state_q == W_G) ? 21'(y) : x_q;
  assign e2_out   = exp2_neg(e2_in);

  always_comb begin
    mul_a = req_q.px;
    mul_b = req_q.px;
    case (state_q)
      W_M2:    begin mul_a = req_q.py;          mul_b = req_q.py;          end
      W_M3:    begin mul_a = P_W'(req_q.vx);    mul_b = P_W'(req_q.vx);    end
      W_M4:    begin mul_a = P_W'(req_q.vy);    mul_b = P_W'(req_q.vy);    end
      W_M5:    begin mul_a = req_q.px;          mul_b = P_W'(req_q.vx);    end
      W_M6:    begin mul_a = req_q.py;          mul_b = P_W'(req_q.vy);    end
      W_PL:    begin mul_a = P_W'(d_q[17:0]);   mul_b = P_W'(g_q);         end
      W_PH:    begin mul_a = P_W'(d_q[35:18]);  mul_b = P_W'(g_q);         end
      W_X:     begin mul_a = P_W'(e_q);         mul_b = P_W'(LOG2E_Q16);   end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    sq_in    = RAD_W'(d_q[35:0]) << 10;
    dv_start = 1'b0;
    dv_num   = RAD_W'(mag[33:0]) << 16;
    dv_den   = np_q;
    fin_x    = 1'b0;
    unique case (state_q)
      W_IDLE: if (start_i && !zero_vec) state_d = W_M1;
      W_M1:   state_d = W_M2;
      W_M2:   state_d = W_M3;
      W_M3:   state_d = W_M4;
      W_M4:   state_d = W_M5;
      W_M5:   state_d = W_M6;
      W_M6:   state_d = W_CHK;
      W_CHK: begin
        if (d_q[49:36] != '0) begin
          state_d = W_IDLE;
          fin_x   = 1'b1;
        end else begin
          sq_start = 1'b1;
          state_d  = W_SQP;
        end
      end
      W_SQP: begin
        sq_in = RAD_W'(vv_q) << 20;
        if (sq_done) begin
          sq_start = 1'b1;
          state_d  = W_SQV;
        end
      end
      W_SQV: begin
        if (sq_done) begin
          dv_start = 1'b1;
          state_d  = W_DT;
        end
      end
      W_DT: begin
        dv_num = NUM_W'(dv_quo[36:0]) << 15;
        dv_den = nv_q;
        if (dv_done) begin
          dv_start = 1'b1;
          state_d  = W_DC;
        end
      end
      W_DC:   if (dv_done) state_d = W_G;
      W_G:    state_d = W_PL;
      W_PL:   state_d = W_PH;
      W_PH:   state_d = W_DS;
      W_DS: begin
        dv_num   = prod_q;
        dv_den   = (spread_i == '0) ? DEN_W'(1) : DEN_W'(spread_i);
        dv_start = 1'b1;
        state_d  = W_DE;
      end
      W_DE: begin
        if (dv_done) begin
          if (dv_quo[NUM_W-1:20] != '0) begin
            state_d = W_IDLE;
            fin_x   = 1'b1;
          end else begin
            state_d = W_X;
          end
        end
      end
      W_X:    state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == W_IDLE && start_i && zero_vec) || fin_x ||
                 (state_q == W_X);
    end
  end

  // working registers; weight_q holds zero for every early exit
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      W_IDLE: begin
        req_q    <= req_i;
        weight_q <= '0;
      end
      W_M1: d_q   <= 50'(mprod);
      W_M2: d_q   <= d_q + 50'(mprod);
      W_M3: vv_q  <= mprod[31:0];
      W_M4: vv_q  <= vv_q + mprod[31:0];
      W_M5: dot_q <= mprod[41:0];
      W_M6: dot_q <= dot_q + mprod[41:0];
      W_CHK: weight_q <= '0;
      W_SQP: if (sq_done) np_q <= sq_root;
      W_SQV: if (sq_done) nv_q <= sq_root;
      W_DC: if (dv_done) c_q <= (dv_quo > NUM_W'(65536)) ? 17'd65536 : dv_quo[16:0];
      W_G:  g_q    <= e2_out;
      W_PL: prod_q <= NUM_W'(mprod[34:0]);
      W_PH: prod_q <= prod_q + (NUM_W'(mprod[34:0]) << 18);
      W_DE: begin
        weight_q <= '0;
        if (dv_done) e_q <= dv_quo[19:0];
      end
      W_X:  x_q <= mprod[36:16];
      default: ;
    endcase
  end

  // final exponent: registered x feeds 2^-x in the cycle after W_X
  logic        fin_q;
  logic [15:0] wout_q;
  // marks that the finishing path went through W_X
  logic        x_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_q) begin
      if (state_q == W_IDLE && x_valid_q) begin
        wout_q <= (e2_out > 17'd65535) ? 16'hFFFF : e2_out[15:0];
      end else begin
        wout_q <= weight_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
    end else if (state_q == W_X) begin
      x_valid_q <= 1'b1;
    end else if (done_q) begin
      x_valid_q <= 1'b0;
    end
  end

  assign done_o   = fin_q;
  assign weight_o = wout_q;

  dgpw_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_in),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  dgpw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .done_o  (dv_done),
    .quo_o   (dv_quo)
  );

endmodule

`default_nettype wire

FILE: test/tb_directional_gaussian_point_warp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directional_gaussian_point_warp_top
// Self-checking bench for the point warp: control loads and point requests
// are driven on the input stream with random gaps. A behavioural model
// predicts each warped point, and the output stream is compared with the
// predictions in order. The run steps through several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_directional_gaussian_point_warp_top import dgpw_pkg::*;;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  directional_gaussian_point_warp_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  longint org_x [16];
  longint org_y [16];
  longint drag_x [16];
  longint drag_y [16];
  int     cur_mode;
  int     cur_count;
  int     cur_spread;

  point_t warped_q [$];
  int     mismatches = 0;
  bit     src_stall = 1'b1;
  bit     sink_stall = 1'b1;

  localparam longint unsigned POW2_Q16 [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
    92682, 96785, 101070, 105545, 110218, 115098, 120193, 125515, 131072
  };

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned pow2_frac(longint unsigned t);
    longint unsigned k;
    longint unsigned f;
    k = t >> 12;
    f = t & 64'hFFF;
    if (k >= 16) return POW2_Q16[16];
    return POW2_Q16[k] + (((POW2_Q16[k+1] - POW2_Q16[k]) * f) >> 12);
  endfunction

  function automatic longint unsigned pow2_neg(longint unsigned v);
    longint unsigned n;
    n = v >> 16;
    if (n >= 40) return 0;
    return pow2_frac(65536 - (v & 64'hFFFF)) >> (n + 1);
  endfunction

  function automatic longint unsigned gauss_weight(longint px, longint py,
                                                   longint vx, longint vy);
    longint unsigned d, vv, mag, np, nv, t, c, g, e, lx, w, sc;
    longint dot, cs;
    if ((vx == 0 && vy == 0) || (px == 0 && py == 0)) return 0;
    d = px * px + py * py;
    if (d >= (64'd1 << 36)) return 0;
    vv  = vx * vx + vy * vy;
    dot = px * vx + py * vy;
    mag = (dot < 0) ? -dot : dot;
    np  = int_sqrt(d << 10);
    nv  = int_sqrt(vv << 20);
    t   = (mag << 16) / np;
    c   = (t << 15) / nv;
    if (c > 65536) c = 65536;
    cs  = (dot < 0) ? -longint'(c) : longint'(c);
    g   = pow2_neg(longint'(65536) - cs);
    sc  = (cur_spread == 0) ? 1 : cur_spread;
    e   = (d * g) / sc;
    if (e >= (64'd16 << 16)) return 0;
    lx  = (e * 94548) >> 16;
    w   = pow2_neg(lx);
    return (w > 65535) ? 65535 : w;
  endfunction

  function automatic longint clip16(longint v);
    return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
  endfunction

  function automatic point_t warp_point(longint x0, longint y0);
    longint cx, cy, rx, ry, w;
    int     n;
    point_t r;
    cx = x0;
    cy = y0;
    n = (cur_count > 16) ? 16 : cur_count;
    for (int i = 0; i < n; i++) begin
      rx = cur_mode ? cx : x0;
      ry = cur_mode ? cy : y0;
      w  = gauss_weight(org_x[i] - rx, org_y[i] - ry, drag_x[i], drag_y[i]);
      cx = clip16((cx * 65536 + w * drag_x[i]) / 65536);
      cy = clip16((cy * 65536 + w * drag_y[i]) / 65536);
    end
    r.x = cx[15:0];
    r.y = cy[15:0];
    return r;
  endfunction

  // send one request; hold valid high across back-to-back requests
  task automatic send_req(logic fn, logic [3:0] slot, logic signed [15:0] x,
                          logic signed [15:0] y, logic signed [15:0] dx,
                          logic signed [15:0] dy);
    int gap;
    gap = src_stall ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {4'b0, dy, dx, y, x, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (fn == FUNC_LOAD) begin
      org_x[slot]  = x;
      org_y[slot]  = y;
      drag_x[slot] = dx;
      drag_y[slot] = dy;
    end else begin
      warped_q.push_back(warp_point(x, y));
    end
  endtask

  task automatic drain;
    if (s_axis_tvalid) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (warped_q.size() != 0) @(posedge clk_i);
    // a trailing load may still be in progress
    repeat (5) @(posedge clk_i);
  endtask

  task automatic set_regs(int mode, int count, int spread);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WARP_MODE;
    cfg_data_i <= 16'(mode);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CONTROL_COUNT;
    cfg_data_i <= 16'(count);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPREAD_SCALE;
    cfg_data_i <= 16'(spread);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_mode   = mode;
    cur_count  = count;
    cur_spread = spread;
  endtask

  function automatic logic signed [15:0] near(longint base, int span);
    return 16'(clip16(base + $signed($urandom_range(0, 2 * span)) - span));
  endfunction

  function automatic logic signed [15:0] any16();
    return 16'($urandom());
  endfunction

  // directed: extremes, zero vectors, far points, large count, zero scale
  task automatic test_directed;
    set_regs(1, 16, 0);
    send_req(FUNC_LOAD, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_req(FUNC_LOAD, 4'd1, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_req(FUNC_LOAD, 4'd2, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    for (int i = 3; i < 16; i++)
      send_req(FUNC_LOAD, 4'(i), near(0, 40), near(0, 40), near(0, 200), near(0, 200));
    send_req(FUNC_WARP, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_req(FUNC_WARP, 4'd0, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
    send_req(FUNC_WARP, 4'd15, -16'sd32768, -16'sd32768, -16'sd1, -16'sd1);
    set_regs(0, 31, 65535);
    send_req(FUNC_WARP, 4'd0, 16'sd10, -16'sd5, 16'sd0, 16'sd0);
    send_req(FUNC_WARP, 4'd0, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0);
    set_regs(0, 0, 1);
    send_req(FUNC_WARP, 4'd0, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0);
  endtask

  task automatic test_random(int mode, int count, int spread, int items,
                             int span, bit calm, bit pause);
    int slot, lim;
    set_regs(mode, count, spread);
    src_stall  = !calm;
    sink_stall = !calm;
    lim = (count > 16) ? 16 : ((count == 0) ? 1 : count);
    for (int k = 0; k < items; k++) begin
      if (pause && k == items / 2) begin
        // hold off until the block has returned every point
        drain();
      end
      slot = $urandom_range(0, lim - 1);
      case ($urandom_range(0, 19))
        0, 1:
          send_req(FUNC_LOAD, 4'(slot), near(0, 1000), near(0, 1000),
                   near(0, 300), near(0, 300));
        2:
          send_req(FUNC_LOAD, 4'($urandom()), any16(), any16(), any16(), any16());
        3, 4, 5:
          send_req(FUNC_WARP, 4'($urandom()), any16(), any16(), any16(), any16());
        default:
          send_req(FUNC_WARP, 4'($urandom()), near(org_x[slot], span),
                   near(org_y[slot], span), any16(), any16());
      endcase
    end
    src_stall  = 1'b1;
    sink_stall = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cur_mode   = 0;
    cur_count  = 0;
    cur_spread = 8000;
    test_directed();
    test_random(0, 2, 8000, 300, 400, 1'b0, 1'b1);
    test_random(1, 3, 65535, 300, 1200, 1'b0, 1'b0);
    test_random(0, 1, 1, 250, 8, 1'b1, 1'b0);
    test_random(1, 4, 0, 300, 6, 1'b0, 1'b0);
    test_random(0, 0, 300, 250, 100, 1'b0, 1'b0);
    test_random(1, 16, 20000, 40, 700, 1'b0, 1'b0);
    test_random(0, 31, 5000, 20, 300, 1'b0, 1'b0);
    test_random(1, 5, 12345, 300, 500, 1'b0, 1'b0);
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && warped_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // output side stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = sink_stall ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (warped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %h", m_axis_tdata);
      end else begin
        want = warped_q.pop_front();
        if (m_axis_tdata[15:0] !== want.x || m_axis_tdata[31:16] !== want.y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: want x=%0d y=%0d got x=%0d y=%0d",
                     want.x, want.y, $signed(m_axis_tdata[15:0]),
                     $signed(m_axis_tdata[31:16]));
        end
      end
    end
  end

  initial begin
    #400_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
